FILE: rtl/core/sha256_block_compress_macros.svh
// ----------------------------------------------------------------------------
// sha256_block_compress_macros.svh
// Assertion macros used by the SHA-256 block compression checker.
// ----------------------------------------------------------------------------
`ifndef SHA256_BLOCK_COMPRESS_MACROS_SVH
`define SHA256_BLOCK_COMPRESS_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SHABC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SHABC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/shabc_pkg.sv
// ----------------------------------------------------------------------------
// shabc_pkg
// Types and constants of the SHA-256 block compression core.
// ----------------------------------------------------------------------------
package shabc_pkg;

  localparam int WORD_W     = 32;
  localparam int HASH_WORDS = 8;
  localparam int MSG_WORDS  = 16;
  localparam int ROUNDS     = 64;
  localparam int ROUND_W    = $clog2(ROUNDS);
  localparam int MSG_IDX_W  = $clog2(MSG_WORDS);
  localparam int HASH_IDX_W = $clog2(HASH_WORDS);

  localparam logic [MSG_IDX_W-1:0]  LAST_MSG_INDEX  = MSG_IDX_W'(MSG_WORDS - 1);
  localparam logic [HASH_IDX_W-1:0] LAST_HASH_INDEX = HASH_IDX_W'(HASH_WORDS - 1);
  localparam logic [ROUND_W-1:0]    LAST_ROUND      = ROUND_W'(ROUNDS - 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [HASH_WORDS-1:0] hash_words_t;
  typedef word_t [MSG_WORDS-1:0] msg_words_t;

  typedef enum logic {
    CMD_LOAD_HASH = 1'b0,
    CMD_MSG_WORD  = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 command;
    logic [3:0]           word_index;
    logic [WORD_W-1:0]    data_word;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]    digest_word;
    logic [2:0]           digest_index;
    logic                 last_word;
  } out_item_t;

  typedef struct packed {
    logic                 load;
    logic                 step;
    logic [ROUND_W-1:0]   round;
  } dp_ctrl_t;

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

endpackage

FILE: rtl/core/shabc_round.sv
// ----------------------------------------------------------------------------
// shabc_round
// Shared SHA-256 round unit: working variables and a 16-word schedule window,
// one round and one schedule expansion per step.
// ----------------------------------------------------------------------------
module shabc_round (
  input  logic                  clk,
  input  shabc_pkg::dp_ctrl_t   ctrl,
  input  shabc_pkg::hash_words_t hash_in,
  input  shabc_pkg::msg_words_t block_in,
  output shabc_pkg::hash_words_t vars
);

  function automatic shabc_pkg::word_t rotr(input shabc_pkg::word_t x, input int n);
    return (x >> n) | (x << (shabc_pkg::WORD_W - n));
  endfunction

  shabc_pkg::hash_words_t v;
  shabc_pkg::msg_words_t  w;

  shabc_pkg::word_t s_lo0, s_lo1, s_up0, s_up1, ch, maj, t1, t2, w_new, k;

  always_comb begin
    k     = shabc_pkg::ROUND_K[ctrl.round];
    s_lo0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s_lo1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = s_lo1 + w[9] + s_lo0 + w[0];
    s_up0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    s_up1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = v[7] + s_up1 + ch + k + w[0];
    t2    = s_up0 + maj;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      v <= hash_in;
      w <= block_in;
    end else if (ctrl.step) begin
      v <= {v[6:4], v[3] + t1, v[2:0], t1 + t2};
      w <= {w_new, w[shabc_pkg::MSG_WORDS-1:1]};
    end
  end

  assign vars = v;

endmodule

FILE: rtl/core/sha256_block_compress.sv
// ----------------------------------------------------------------------------
// sha256_block_compress
// SHA-256 compression of one 512-bit block with command-style input.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred when start is high and busy is low. Command
//   load-hash writes chaining word word_index (0..7; 8..15 is ignored).
//   Command message-word stores block word word_index (0..15). Each write
//   to word 15 compresses the block with the stored chaining words.
//   Loads and words 0..14 produce nothing. A compression keeps busy high
//   through the round state, where the single shared round unit runs one
//   round per cycle, the final state, which adds the working variables
//   into the chaining words, and the output state. The eight updated
//   chaining words follow on result, one per cycle, each marked by
//   result_strobe for one cycle; last_word marks word 7.
//   The receiver cannot stall; results must be taken as they appear.
//   Reset clears the chaining words to zero and returns to idle; message
//   words hold no reset value and must be written before use.
// ----------------------------------------------------------------------------
module sha256_block_compress (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  shabc_pkg::in_item_t   item,
  output shabc_pkg::out_item_t  result,
  output logic                  result_strobe
);

  shabc_pkg::state_t   state, state_next;
  logic [shabc_pkg::ROUND_W-1:0] count;
  shabc_pkg::hash_words_t hash;
  shabc_pkg::hash_words_t vars;
  shabc_pkg::msg_words_t  msg, msg_next;
  shabc_pkg::dp_ctrl_t  ctrl;

  logic accept, go, out_last;
  logic [shabc_pkg::HASH_IDX_W-1:0] out_idx;

  assign accept   = start && !busy;
  assign go       = accept && (item.command == shabc_pkg::CMD_MSG_WORD)
                    && (item.word_index == shabc_pkg::LAST_MSG_INDEX);
  assign out_idx  = count[shabc_pkg::HASH_IDX_W-1:0];
  assign out_last = (out_idx == shabc_pkg::LAST_HASH_INDEX);

  always_comb begin
    msg_next = msg;
    msg_next[item.word_index] = item.data_word;
  end

  always_comb begin
    state_next = state;
    case (state)
      shabc_pkg::ST_IDLE:  if (go) state_next = shabc_pkg::ST_ROUND;
      shabc_pkg::ST_ROUND: if (count == shabc_pkg::LAST_ROUND) state_next = shabc_pkg::ST_FINAL;
      shabc_pkg::ST_FINAL: state_next = shabc_pkg::ST_OUT;
      shabc_pkg::ST_OUT:   if (out_last) state_next = shabc_pkg::ST_IDLE;
      default:             state_next = shabc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != shabc_pkg::ST_IDLE);
    ctrl.load  = go;
    ctrl.step  = (state == shabc_pkg::ST_ROUND);
    ctrl.round = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= shabc_pkg::ST_IDLE;
      count         <= '0;
      hash          <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= (state == shabc_pkg::ST_OUT);
      if (state == shabc_pkg::ST_ROUND) begin
        count <= count + 1'b1;
      end else if (state == shabc_pkg::ST_OUT) begin
        count <= out_last ? '0 : count + 1'b1;
      end
      if (accept && item.command == shabc_pkg::CMD_LOAD_HASH && !item.word_index[3]) begin
        hash[item.word_index[shabc_pkg::HASH_IDX_W-1:0]] <= item.data_word;
      end else if (state == shabc_pkg::ST_FINAL) begin
        for (int i = 0; i < shabc_pkg::HASH_WORDS; i++) begin
          hash[i] <= hash[i] + vars[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.command == shabc_pkg::CMD_MSG_WORD) begin
      msg <= msg_next;
    end
    if (state == shabc_pkg::ST_OUT) begin
      result.digest_word  <= hash[out_idx];
      result.digest_index <= out_idx;
      result.last_word    <= out_last;
    end
  end

  shabc_round u_round (
    .clk      (clk),
    .ctrl     (ctrl),
    .hash_in  (hash),
    .block_in (msg_next),
    .vars     (vars)
  );

endmodule

FILE: rtl/core/shabc_check.sv
// ----------------------------------------------------------------------------
// shabc_check
// Port-level checks on the SHA-256 block compression core, bound to the top.
// ----------------------------------------------------------------------------
`include "sha256_block_compress_macros.svh"

module shabc_check (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input shabc_pkg::in_item_t  item,
  input shabc_pkg::out_item_t result,
  input logic                 result_strobe
);

  `SHABC_ASSERT_NEXT(a_last_starts, start && !busy && item.command == shabc_pkg::CMD_MSG_WORD && item.word_index == shabc_pkg::LAST_MSG_INDEX, busy, "last message word did not start a compression")
  `SHABC_ASSERT_NOW(a_last_index, result_strobe && result.last_word, result.digest_index == shabc_pkg::LAST_HASH_INDEX, "last_word on wrong index")
  `SHABC_ASSERT_NEXT(a_burst_order, result_strobe && !result.last_word, result_strobe && result.digest_index == $past(result.digest_index) + 3'd1, "digest burst broken")
  `SHABC_ASSERT_NOW(a_busy_burst, result_strobe && !result.last_word, busy, "busy dropped inside a digest burst")
  `SHABC_ASSERT_NOW(a_burst_first, $rose(result_strobe), result.digest_index == 3'd0, "digest burst does not start at word 0")

endmodule

bind sha256_block_compress shabc_check u_check (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .item          (item),
  .result        (result),
  .result_strobe (result_strobe)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sha256_block_compress. Commands go in through the
// start/busy handshake with random gaps; a scoreboard keeps its own copy of
// the chaining and block words, computes the compression on every write of
// block word 15, and compares each strobed digest word with the next one
// expected. A known block with the standard initial value comes first, then
// random blocks, partial rewrites and stray commands.
// ----------------------------------------------------------------------------
module tb_top;

  localparam shabc_pkg::word_t SHA_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam shabc_pkg::word_t SHA_IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  class sha256_scoreboard;
    shabc_pkg::word_t     chain [8];
    shabc_pkg::word_t     block [16];
    shabc_pkg::out_item_t digest_q [$];
    int                   errors;

    function new();
      foreach (chain[i]) chain[i] = '0;
      foreach (block[i]) block[i] = '0;
      errors = 0;
    endfunction

    function shabc_pkg::word_t rotr(shabc_pkg::word_t v, int n);
      return (v >> n) | (v << (32 - n));
    endfunction

    function shabc_pkg::word_t ssig0(shabc_pkg::word_t x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function shabc_pkg::word_t ssig1(shabc_pkg::word_t x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function shabc_pkg::word_t bsig0(shabc_pkg::word_t x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function shabc_pkg::word_t bsig1(shabc_pkg::word_t x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function void compress();
      shabc_pkg::word_t w [64];
      shabc_pkg::word_t v [8];
      shabc_pkg::word_t t1;
      shabc_pkg::word_t t2;
      for (int t = 0; t < 16; t++) w[t] = block[t];
      for (int t = 16; t < 64; t++)
        w[t] = ssig1(w[t-2]) + w[t-7] + ssig0(w[t-15]) + w[t-16];
      foreach (v[i]) v[i] = chain[i];
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
        t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      foreach (chain[i]) chain[i] = chain[i] + v[i];
    endfunction

    function void note_input(shabc_pkg::in_item_t it);
      shabc_pkg::out_item_t exp_item;
      if (shabc_pkg::command_t'(it.command) == shabc_pkg::CMD_LOAD_HASH) begin
        if (it.word_index < 4'd8) chain[it.word_index[2:0]] = it.data_word;
      end else begin
        block[it.word_index] = it.data_word;
        if (it.word_index == shabc_pkg::LAST_MSG_INDEX) begin
          compress();
          for (int k = 0; k < 8; k++) begin
            exp_item.digest_word  = chain[k];
            exp_item.digest_index = 3'(k);
            exp_item.last_word    = (k == 7);
            digest_q.push_back(exp_item);
          end
        end
      end
    endfunction

    function void check_result(shabc_pkg::out_item_t got);
      shabc_pkg::out_item_t exp_item;
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h index %0d", got.digest_word, got.digest_index);
        errors++;
        return;
      end
      exp_item = digest_q.pop_front();
      if (got.digest_word !== exp_item.digest_word) begin
        $error("digest_word: expected %h, actual %h", exp_item.digest_word, got.digest_word);
        errors++;
      end
      if (got.digest_index !== exp_item.digest_index) begin
        $error("digest_index: expected %0d, actual %0d",
               exp_item.digest_index, got.digest_index);
        errors++;
      end
      if (got.last_word !== exp_item.last_word) begin
        $error("last_word: expected %b, actual %b", exp_item.last_word, got.last_word);
        errors++;
      end
    endfunction

    function int pending();
      return digest_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  shabc_pkg::in_item_t  item = '0;
  shabc_pkg::out_item_t result;
  logic                 result_strobe;

  sha256_scoreboard sb = new();
  int transfers = 0;

  sha256_block_compress dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result        (result),
    .result_strobe (result_strobe)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_strobe) sb.check_result(result);
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic shabc_pkg::word_t rand_word();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return shabc_pkg::word_t'($urandom);
  endfunction

  // one command transfer; start stays high until busy is low at an edge
  task automatic send_item(input shabc_pkg::command_t cmd, input logic [3:0] idx,
                           input shabc_pkg::word_t data);
    shabc_pkg::in_item_t it;
    bit                  quiet;
    it.command    = cmd;
    it.word_index = idx;
    it.data_word  = data;
    quiet = (transfers >= 70 && transfers < 120);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 31) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
    if (!(cmd == shabc_pkg::CMD_LOAD_HASH && idx >= 4'd8)) transfers++;
  endtask

  task automatic random_block();
    int r;
    r = $urandom_range(2);
    if (r == 0) begin
      for (int i = 0; i < 8; i++) send_item(shabc_pkg::CMD_LOAD_HASH, 4'(i), rand_word());
    end else if (r == 1) begin
      repeat ($urandom_range(1, 3))
        send_item(shabc_pkg::CMD_LOAD_HASH, 4'($urandom_range(7)), rand_word());
    end
    if ($urandom_range(1) == 0) begin
      for (int i = 0; i < 16; i++) send_item(shabc_pkg::CMD_MSG_WORD, 4'(i), rand_word());
    end else begin
      repeat ($urandom_range(0, 6))
        send_item(shabc_pkg::CMD_MSG_WORD, 4'($urandom_range(14)), rand_word());
      send_item(shabc_pkg::CMD_MSG_WORD, shabc_pkg::LAST_MSG_INDEX, rand_word());
    end
  endtask

  initial begin
    int r;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // standard initial value, stray load, padded "abc" block, repeated last word
    for (int i = 0; i < 8; i++) send_item(shabc_pkg::CMD_LOAD_HASH, 4'(i), SHA_IV[i]);
    send_item(shabc_pkg::CMD_LOAD_HASH, 4'd15, 32'hFFFF_FFFF);
    send_item(shabc_pkg::CMD_MSG_WORD, 4'd0, 32'h6162_6380);
    for (int i = 1; i < 15; i++) send_item(shabc_pkg::CMD_MSG_WORD, 4'(i), '0);
    send_item(shabc_pkg::CMD_MSG_WORD, shabc_pkg::LAST_MSG_INDEX, 32'h0000_0018);
    send_item(shabc_pkg::CMD_MSG_WORD, shabc_pkg::LAST_MSG_INDEX, 32'hFFFF_FFFF);

    while (transfers < 180) begin
      r = $urandom_range(99);
      if (r < 70) begin
        random_block();
      end else if (r < 85) begin
        send_item(shabc_pkg::command_t'($urandom_range(1)), 4'($urandom_range(15)),
                  rand_word());
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(shabc_pkg::CMD_MSG_WORD, 4'($urandom_range(14)), rand_word());
      end
    end
    @(negedge clk);
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
